// ===== rtl/frame_bitmap_allocator_assert.svh =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator assertion macros
// Concurrent check helpers shared by the allocator RTL.
// ----------------------------------------------------------------------------
`ifndef FRAME_BITMAP_ALLOCATOR_ASSERT_SVH
`define FRAME_BITMAP_ALLOCATOR_ASSERT_SVH

// The condition implies the expression in the same cycle.
`define FBA_ASSERT_IMPLIES(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (expr)) \
        else $error(msg);

// The condition implies the expression in the next cycle.
`define FBA_ASSERT_NEXT(label, clk, rst_n, cond, expr, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (expr)) \
        else $error(msg);

`endif

// ===== rtl/fba_pkg.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator package
// Field widths, codes and shared types of the frame bitmap allocator.
// ----------------------------------------------------------------------------
package fba_pkg;

    localparam int MAX_FRAMES_DEF    = 32768;
    localparam int MAP_WORD_BITS_DEF = 32;

    localparam int CFG_W      = 16;
    localparam int OPCODE_W   = 2;
    localparam int INDEX_W    = 15;
    localparam int STATUS_W   = 2;
    localparam int GRANT_W    = 15;
    localparam int ENTRY_W    = 27;
    localparam int PAGE_SHIFT = 12;

    localparam logic [CFG_W-1:0] FRAME_COUNT_RESET = 16'd32768;
    localparam logic [CFG_W-1:0] RESERVED_RESET    = 16'd3840;

    localparam logic [PAGE_SHIFT-1:0] PTE_PRESENT  = 12'h001;
    localparam logic [PAGE_SHIFT-1:0] PTE_WRITABLE = 12'h002;
    localparam logic [PAGE_SHIFT-1:0] PTE_FLAGS    = PTE_PRESENT | PTE_WRITABLE;

    typedef enum logic [OPCODE_W-1:0] {
        OP_INIT      = 2'd0,
        OP_MARK_USED = 2'd1,
        OP_MARK_FREE = 2'd2,
        OP_ALLOC     = 2'd3
    } opcode_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK      = 2'd0,
        ST_NO_FREE = 2'd1,
        ST_RANGE   = 2'd2
    } status_t;

    typedef enum logic {
        REG_FRAME_COUNT     = 1'b0,
        REG_RESERVED_FRAMES = 1'b1
    } cfg_reg_t;

    // Operations of the shared word unit.
    typedef enum logic [1:0] {
        UOP_FILL  = 2'd0,
        UOP_SET   = 2'd1,
        UOP_CLEAR = 2'd2,
        UOP_ALLOC = 2'd3
    } uop_t;

    typedef struct packed {
        logic found;
        logic more;
    } unit_flags_t;

    typedef enum logic [4:0] {
        S_INIT   = 5'b00001,
        S_IDLE   = 5'b00010,
        S_MWRITE = 5'b00100,
        S_ASCAN  = 5'b01000,
        S_DONE   = 5'b10000
    } state_t;

endpackage

// ===== rtl/fba_map_mem.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap memory
// Single write port, single read port, registered read data.
// ----------------------------------------------------------------------------
module fba_map_mem #(
    parameter int WORDS  = 1024,
    parameter int WIDTH  = 32,
    parameter int ADDR_W = 10
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [WORDS];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    always_ff @(posedge clk)
    begin
        rd_data <= mem[rd_addr];
    end

endmodule

// ===== rtl/fba_word_unit.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap word unit
// Works on one bitmap word: fills it up to a frame limit, sets or clears one
// bit, or finds and claims the lowest free bit below the frame limit.
// ----------------------------------------------------------------------------
module fba_word_unit #(
    parameter int WORD_BITS = 32,
    parameter int BIT_W     = 5,
    parameter int DIFF_W    = 17
) (
    input  fba_pkg::uop_t        uop,
    input  logic [WORD_BITS-1:0] word_in,
    input  logic [DIFF_W-1:0]    base,
    input  logic [DIFF_W-1:0]    limit,
    input  logic [BIT_W-1:0]     bit_sel,
    output logic [WORD_BITS-1:0] word_out,
    output logic [BIT_W-1:0]     hit_bit,
    output fba_pkg::unit_flags_t flags
);

    logic [DIFF_W-1:0]    diff;
    logic                 neg;
    logic                 full;
    logic [BIT_W-1:0]     rem_low;
    logic [WORD_BITS-1:0] lane_mask;
    logic [WORD_BITS-1:0] free_bits;
    logic [WORD_BITS-1:0] lowest;
    logic [WORD_BITS-1:0] onehot;

    // Frames left between this word's first frame and the limit.
    assign diff    = limit - base;
    assign neg     = diff[DIFF_W-1];
    assign full    = !neg && (diff >= DIFF_W'(WORD_BITS));
    assign rem_low = diff[BIT_W-1:0];

    always_comb
    begin
        for (int b = 0; b < WORD_BITS; b++)
        begin
            lane_mask[b] = full || (!neg && (BIT_W'(b) < rem_low));
        end
    end

    assign free_bits = ~word_in & lane_mask;
    assign lowest    = free_bits & (~free_bits + WORD_BITS'(1));
    assign onehot    = WORD_BITS'(1) << bit_sel;

    always_comb
    begin
        hit_bit = '0;
        for (int b = 0; b < WORD_BITS; b++)
        begin
            if (lowest[b])
            begin
                hit_bit = hit_bit | BIT_W'(b);
            end
        end
    end

    always_comb
    begin
        case (uop)
            fba_pkg::UOP_FILL:  word_out = lane_mask;
            fba_pkg::UOP_SET:   word_out = word_in | onehot;
            fba_pkg::UOP_CLEAR: word_out = word_in & ~onehot;
            fba_pkg::UOP_ALLOC: word_out = word_in | lowest;
            default:            word_out = word_in;
        endcase
    end

    assign flags.found = |free_bits;
    assign flags.more  = !neg && (diff > DIFF_W'(WORD_BITS));

endmodule

// ===== rtl/frame_bitmap_allocator.sv =====
// ----------------------------------------------------------------------------
// Frame bitmap allocator
// Keeps one bit per physical frame in an on-chip bitmap, one word per row.
// Input words (opcode, frame_index) arrive on in_valid/in_stall and each
// yields exactly one result word (status, granted_frame, page_entry) on
// out_valid/out_stall. Registers frame_count and reserved_frames are written
// through cfg_valid/cfg_ready, which is always ready.
// From acceptance to out_valid: mark used or mark free passes S_MWRITE, then
// S_DONE; an out-of-range index or an empty map goes straight to S_DONE; init
// sweeps every bitmap word in S_INIT; allocate scans words in S_ASCAN.
// One shared word unit serves every operation and the bitmap memory gives one
// word per cycle, so the allocate scan, at one word per cycle, sets the rate.
// After reset the block sweeps every bitmap word, clearing it and marking
// the first 3840 frames used; in_stall is high meanwhile.
// A finished result sits in the output register while the receiver stalls
// and the next input word is taken; a second result waits until that one
// has left. MAP_WORD_BITS must be a power of two.
// ----------------------------------------------------------------------------
module frame_bitmap_allocator #(
    parameter int MAX_FRAMES    = fba_pkg::MAX_FRAMES_DEF,
    parameter int MAP_WORD_BITS = fba_pkg::MAP_WORD_BITS_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [fba_pkg::OPCODE_W-1:0]  opcode,
    input  logic [fba_pkg::INDEX_W-1:0]   frame_index,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic [fba_pkg::STATUS_W-1:0]  status,
    output logic [fba_pkg::GRANT_W-1:0]   granted_frame,
    output logic [fba_pkg::ENTRY_W-1:0]   page_entry,
    input  logic                          cfg_valid,
    output logic                          cfg_ready,
    input  logic                          cfg_index,
    input  logic [fba_pkg::CFG_W-1:0]     cfg_data
);

    localparam int MAP_WORDS = (MAX_FRAMES + MAP_WORD_BITS - 1) / MAP_WORD_BITS;
    localparam int WADDR_W   = (MAP_WORDS > 1) ? $clog2(MAP_WORDS) : 1;
    localparam int BIT_W     = $clog2(MAP_WORD_BITS);
    localparam int FR_W      = WADDR_W + BIT_W;
    localparam int CNT_W     = $clog2(MAX_FRAMES + 1);
    localparam int DIFF_W    = ((CNT_W > FR_W) ? CNT_W : FR_W) + 1;
    localparam logic [WADDR_W-1:0] LAST_WORD = WADDR_W'(MAP_WORDS - 1);

    function automatic logic [CNT_W-1:0] clamp_frames(input logic [fba_pkg::CFG_W-1:0] v);
        clamp_frames = (32'(v) > 32'(MAX_FRAMES)) ? CNT_W'(MAX_FRAMES) : CNT_W'(v);
    endfunction

    localparam logic [CNT_W-1:0] RESET_FILL = clamp_frames(fba_pkg::RESERVED_RESET);

    // Configuration registers.
    logic [fba_pkg::CFG_W-1:0] frame_count_reg;
    logic [fba_pkg::CFG_W-1:0] reserved_reg;

    // Sequencer and result registers.
    fba_pkg::state_t          state_reg, state_next;
    logic [WADDR_W-1:0]       word_reg, word_next;
    logic [BIT_W-1:0]         bit_reg, bit_next;
    fba_pkg::uop_t            op_reg, op_next;
    logic [CNT_W-1:0]         fill_limit_reg, fill_limit_next;
    logic                     init_reply_reg, init_reply_next;
    fba_pkg::status_t         res_status_reg, res_status_next;
    logic [fba_pkg::GRANT_W-1:0] res_grant_reg, res_grant_next;
    logic                     res_hit_reg, res_hit_next;

    // Output register.
    logic                          out_valid_reg;
    logic [fba_pkg::STATUS_W-1:0]  out_status_reg;
    logic [fba_pkg::GRANT_W-1:0]   out_grant_reg;
    logic [fba_pkg::ENTRY_W-1:0]   out_entry_reg;
    logic                          out_load;

    logic [CNT_W-1:0]         count_eff;
    logic                     in_accept;
    logic [31:0]              idx_ext;
    logic                     idx_in_range;
    logic [WADDR_W-1:0]       idx_word;
    logic [BIT_W-1:0]         idx_bit;

    fba_pkg::uop_t            unit_op;
    logic [DIFF_W-1:0]        unit_base;
    logic [DIFF_W-1:0]        unit_limit;
    logic [MAP_WORD_BITS-1:0] unit_word_out;
    logic [BIT_W-1:0]         unit_hit_bit;
    fba_pkg::unit_flags_t     unit_flags;
    logic [FR_W-1:0]          hit_frame;

    logic                     mem_wr_en;
    logic [WADDR_W-1:0]       mem_rd_addr;
    logic [MAP_WORD_BITS-1:0] mem_rd_data;

    assign cfg_ready = 1'b1;
    assign in_stall  = (state_reg != fba_pkg::S_IDLE);
    assign in_accept = in_valid && !in_stall;

    assign count_eff    = clamp_frames(frame_count_reg);
    assign idx_ext      = 32'(frame_index);
    assign idx_in_range = idx_ext < 32'(count_eff);
    assign idx_word     = idx_ext[BIT_W +: WADDR_W];
    assign idx_bit      = idx_ext[BIT_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            frame_count_reg <= fba_pkg::FRAME_COUNT_RESET;
            reserved_reg    <= fba_pkg::RESERVED_RESET;
        end
        else if (cfg_valid && cfg_ready)
        begin
            case (fba_pkg::cfg_reg_t'(cfg_index))
                fba_pkg::REG_FRAME_COUNT:     frame_count_reg <= cfg_data;
                fba_pkg::REG_RESERVED_FRAMES: reserved_reg    <= cfg_data;
                default:                      ;
            endcase
        end
    end

    // Shared word unit inputs follow the sequencer state.
    always_comb
    begin
        unit_op    = fba_pkg::UOP_ALLOC;
        unit_limit = DIFF_W'(count_eff);
        case (state_reg)
            fba_pkg::S_INIT:
            begin
                unit_op    = fba_pkg::UOP_FILL;
                unit_limit = DIFF_W'(fill_limit_reg);
            end
            fba_pkg::S_MWRITE:
            begin
                unit_op = op_reg;
            end
            default:
            begin
                unit_op = fba_pkg::UOP_ALLOC;
            end
        endcase
    end

    assign unit_base = DIFF_W'({word_reg, {BIT_W{1'b0}}});
    assign hit_frame = {word_reg, unit_hit_bit};

    fba_word_unit #(
        .WORD_BITS (MAP_WORD_BITS),
        .BIT_W     (BIT_W),
        .DIFF_W    (DIFF_W)
    ) u_word_unit (
        .uop      (unit_op),
        .word_in  (mem_rd_data),
        .base     (unit_base),
        .limit    (unit_limit),
        .bit_sel  (bit_reg),
        .word_out (unit_word_out),
        .hit_bit  (unit_hit_bit),
        .flags    (unit_flags)
    );

    assign mem_wr_en = (state_reg == fba_pkg::S_INIT) || (state_reg == fba_pkg::S_MWRITE)
                       || ((state_reg == fba_pkg::S_ASCAN) && unit_flags.found);

    // The scan reads the next word while the current one is being checked.
    always_comb
    begin
        case (state_reg)
            fba_pkg::S_IDLE:
            begin
                mem_rd_addr = (fba_pkg::opcode_t'(opcode) == fba_pkg::OP_ALLOC) ? '0 : idx_word;
            end
            fba_pkg::S_ASCAN:
            begin
                mem_rd_addr = word_reg + WADDR_W'(1);
            end
            default:
            begin
                mem_rd_addr = word_reg;
            end
        endcase
    end

    fba_map_mem #(
        .WORDS  (MAP_WORDS),
        .WIDTH  (MAP_WORD_BITS),
        .ADDR_W (WADDR_W)
    ) u_map_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (word_reg),
        .wr_data (unit_word_out),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    assign out_load = (state_reg == fba_pkg::S_DONE) && (!out_valid_reg || !out_stall);

    always_comb
    begin
        state_next      = state_reg;
        word_next       = word_reg;
        bit_next        = bit_reg;
        op_next         = op_reg;
        fill_limit_next = fill_limit_reg;
        init_reply_next = init_reply_reg;
        res_status_next = res_status_reg;
        res_grant_next  = res_grant_reg;
        res_hit_next    = res_hit_reg;
        case (state_reg)
            fba_pkg::S_IDLE:
            begin
                if (in_accept)
                begin
                    res_status_next = fba_pkg::ST_OK;
                    res_grant_next  = '0;
                    res_hit_next    = 1'b0;
                    case (fba_pkg::opcode_t'(opcode))
                        fba_pkg::OP_INIT:
                        begin
                            fill_limit_next = clamp_frames(reserved_reg);
                            init_reply_next = 1'b1;
                            word_next       = '0;
                            state_next      = fba_pkg::S_INIT;
                        end
                        fba_pkg::OP_MARK_USED, fba_pkg::OP_MARK_FREE:
                        begin
                            if (idx_in_range)
                            begin
                                word_next  = idx_word;
                                bit_next   = idx_bit;
                                op_next    = (fba_pkg::opcode_t'(opcode) == fba_pkg::OP_MARK_USED)
                                             ? fba_pkg::UOP_SET : fba_pkg::UOP_CLEAR;
                                state_next = fba_pkg::S_MWRITE;
                            end
                            else
                            begin
                                res_status_next = fba_pkg::ST_RANGE;
                                state_next      = fba_pkg::S_DONE;
                            end
                        end
                        fba_pkg::OP_ALLOC:
                        begin
                            if (count_eff == '0)
                            begin
                                res_status_next = fba_pkg::ST_NO_FREE;
                                state_next      = fba_pkg::S_DONE;
                            end
                            else
                            begin
                                word_next  = '0;
                                state_next = fba_pkg::S_ASCAN;
                            end
                        end
                        default:
                        begin
                            state_next = fba_pkg::S_IDLE;
                        end
                    endcase
                end
            end
            fba_pkg::S_INIT:
            begin
                if (word_reg == LAST_WORD)
                begin
                    state_next = init_reply_reg ? fba_pkg::S_DONE : fba_pkg::S_IDLE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end
            fba_pkg::S_MWRITE:
            begin
                state_next = fba_pkg::S_DONE;
            end
            fba_pkg::S_ASCAN:
            begin
                if (unit_flags.found)
                begin
                    res_grant_next = fba_pkg::GRANT_W'(hit_frame);
                    res_hit_next   = 1'b1;
                    state_next     = fba_pkg::S_DONE;
                end
                else if (!unit_flags.more || (word_reg == LAST_WORD))
                begin
                    res_status_next = fba_pkg::ST_NO_FREE;
                    state_next      = fba_pkg::S_DONE;
                end
                else
                begin
                    word_next = word_reg + WADDR_W'(1);
                end
            end
            fba_pkg::S_DONE:
            begin
                if (out_load)
                begin
                    state_next = fba_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = fba_pkg::S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= fba_pkg::S_INIT;
            word_reg       <= '0;
            fill_limit_reg <= RESET_FILL;
            init_reply_reg <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            word_reg       <= word_next;
            fill_limit_reg <= fill_limit_next;
            init_reply_reg <= init_reply_next;
        end
    end

    always_ff @(posedge clk)
    begin
        bit_reg        <= bit_next;
        op_reg         <= op_next;
        res_status_reg <= res_status_next;
        res_grant_reg  <= res_grant_next;
        res_hit_reg    <= res_hit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            out_status_reg <= res_status_reg;
            out_grant_reg  <= res_grant_reg;
            out_entry_reg  <= res_hit_reg ? {res_grant_reg, fba_pkg::PTE_FLAGS} : '0;
        end
    end

    assign out_valid     = out_valid_reg;
    assign status        = out_status_reg;
    assign granted_frame = out_grant_reg;
    assign page_entry    = out_entry_reg;

    `include "frame_bitmap_allocator_assert.svh"

    // The scan never looks at a word that starts at or beyond the frame count.
    `FBA_ASSERT_IMPLIES(a_scan_below_count, clk, rst_n, state_reg == fba_pkg::S_ASCAN, unit_base < DIFF_W'(count_eff), "allocate scan passed the frame count")

    // A failed result never carries a frame grant or a page entry.
    `FBA_ASSERT_IMPLIES(a_no_grant_on_fail, clk, rst_n, out_valid && (status != fba_pkg::ST_OK), (granted_frame == '0) && (page_entry == '0), "grant reported with a failing status")

    // An in-range mark goes straight to its write-back cycle.
    `FBA_ASSERT_NEXT(a_mark_writeback, clk, rst_n, in_accept && idx_in_range && ((fba_pkg::opcode_t'(opcode) == fba_pkg::OP_MARK_USED) || (fba_pkg::opcode_t'(opcode) == fba_pkg::OP_MARK_FREE)), (state_reg == fba_pkg::S_MWRITE) && mem_wr_en, "mark did not write back its word")

endmodule
